// ===== hw/rtl/cfpw_pkg.sv =====
// Shared types and constants for the command frame parser with drive watchdog.
// Used by every module under hw/rtl; depends on nothing.
package cfpw_pkg;

   localparam int VALUE_BITS = 16;
   localparam int TIMEOUT_BITS = 16;
   localparam int TICK_BITS = TIMEOUT_BITS + 1;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(200);
   localparam logic [VALUE_BITS-1:0] STEER_RESET = VALUE_BITS'(90);
   localparam logic [TICK_BITS-1:0] TICK_CAP = TICK_BITS'(65536);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_PLUS = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // token kinds produced by the classifier
   localparam logic [3:0] KIND_TICK = 4'd0;
   localparam logic [3:0] KIND_NEWLINE = 4'd1;
   localparam logic [3:0] KIND_DOLLAR = 4'd2;
   localparam logic [3:0] KIND_COMMA = 4'd3;
   localparam logic [3:0] KIND_PLUS = 4'd4;
   localparam logic [3:0] KIND_MINUS = 4'd5;
   localparam logic [3:0] KIND_DIGIT = 4'd6;
   localparam logic [3:0] KIND_BLANK = 4'd7;
   localparam logic [3:0] KIND_OTHER = 4'd8;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] steering_angle;
      logic signed [15:0] drive_speed;
      logic               frame_ack;
      logic               failsafe;
   } rsp_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [3:0] digit;
   } token_type;

endpackage

// ===== hw/rtl/cfpw_front.sv =====
// Front end: classifies each incoming item into a token for the queue.
// Depends on cfpw_pkg.
module cfpw_front (
   input  cfpw_pkg::req_type   req,
   output cfpw_pkg::token_type token
);

   logic [7:0] c;

   assign c = req.rx_byte;

   always_comb begin
      token.digit = 4'(c - cfpw_pkg::CHAR_ZERO);
      if (req.opcode == cfpw_pkg::OP_TICK) begin
         token.kind = cfpw_pkg::KIND_TICK;
      end else if (c == cfpw_pkg::CHAR_NEWLINE) begin
         token.kind = cfpw_pkg::KIND_NEWLINE;
      end else if (c == cfpw_pkg::CHAR_DOLLAR) begin
         token.kind = cfpw_pkg::KIND_DOLLAR;
      end else if (c == cfpw_pkg::CHAR_COMMA) begin
         token.kind = cfpw_pkg::KIND_COMMA;
      end else if (c == cfpw_pkg::CHAR_PLUS) begin
         token.kind = cfpw_pkg::KIND_PLUS;
      end else if (c == cfpw_pkg::CHAR_MINUS) begin
         token.kind = cfpw_pkg::KIND_MINUS;
      end else if (c >= cfpw_pkg::CHAR_ZERO && c <= cfpw_pkg::CHAR_NINE) begin
         token.kind = cfpw_pkg::KIND_DIGIT;
      end else if (c == cfpw_pkg::CHAR_SPACE ||
                   (c >= cfpw_pkg::CHAR_TAB && c <= cfpw_pkg::CHAR_CR)) begin
         token.kind = cfpw_pkg::KIND_BLANK;
      end else begin
         token.kind = cfpw_pkg::KIND_OTHER;
      end
   end

endmodule

// ===== hw/rtl/cfpw_queue.sv =====
// Two-entry token queue between the classifier and the executor.
// Depends on cfpw_pkg.
module cfpw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfpw_pkg::token_type push_token,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output cfpw_pkg::token_type pop_token
);

   cfpw_pkg::token_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ===== hw/rtl/cfpw_back.sv =====
// Back end: line parser, number accumulator, watchdog and result register.
// Depends on cfpw_pkg.
module cfpw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  cfpw_pkg::token_type tok,
   output logic                tok_pop,
   input  logic                timeout_wr,
   input  logic [15:0]         timeout_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cfpw_pkg::rsp_type   rsp_payload
);

   localparam int VB = cfpw_pkg::VALUE_BITS;
   localparam int AW = VB + 5;

   localparam logic [1:0] LP_START = 2'd0;
   localparam logic [1:0] LP_STEER = 2'd1;
   localparam logic [1:0] LP_SPEED = 2'd2;
   localparam logic [1:0] LP_SKIP = 2'd3;

   localparam logic [1:0] NP_SPACE = 2'd0;
   localparam logic [1:0] NP_SIGN = 2'd1;
   localparam logic [1:0] NP_DIGITS = 2'd2;
   localparam logic [1:0] NP_DONE = 2'd3;

   function automatic logic signed [VB-1:0] accumulate(
      input logic signed [VB-1:0] acc,
      input logic [3:0]           d,
      input logic                 neg
   );
      logic signed [AW-1:0] v;
      logic signed [AW-1:0] dv;
      logic signed [AW-1:0] maxv;
      logic signed [AW-1:0] minv;
      maxv = {6'b0, {(VB-1){1'b1}}};
      minv = ~maxv;
      dv = signed'({{(AW-4){1'b0}}, d});
      v = (AW'(acc) <<< 3) + (AW'(acc) <<< 1);
      v = neg ? v - dv : v + dv;
      if (v > maxv) v = maxv;
      if (v < minv) v = minv;
      return VB'(v);
   endfunction

   function automatic logic signed [15:0] to_out(input logic signed [VB-1:0] val);
      logic signed [31:0] wide;
      wide = 32'(val);
      return wide[15:0];
   endfunction

   logic [15:0]                   timeout_ff;
   logic [1:0]                    lp_ff, lp_in;
   logic [1:0]                    np_ff, np_in;
   logic                          neg_ff, neg_in;
   logic signed [VB-1:0]          sacc_ff, sacc_in;
   logic signed [VB-1:0]          pacc_ff, pacc_in;
   logic signed [VB-1:0]          steer_ff, steer_in;
   logic signed [VB-1:0]          speed_ff, speed_in;
   logic [cfpw_pkg::TICK_BITS-1:0] ticks_ff, ticks_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   cfpw_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [VB-1:0] num_acc, acc_next;
   logic [1:0]           num_np;
   logic                 num_neg, num_upd;
   logic                 ack, fs;

   assign tok_pop = tok_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // one shared multiply-add serves whichever field's accumulator is open
   assign num_acc = (lp_ff == LP_SPEED) ? pacc_ff : sacc_ff;
   assign acc_next = accumulate(num_acc, tok.digit, neg_ff);

   always_comb begin
      num_np = np_ff;
      num_neg = neg_ff;
      num_upd = 1'b0;
      case (np_ff)
         NP_SPACE: begin
            if (tok.kind == cfpw_pkg::KIND_BLANK) begin
               num_np = NP_SPACE;
            end else if (tok.kind == cfpw_pkg::KIND_PLUS) begin
               num_np = NP_SIGN;
            end else if (tok.kind == cfpw_pkg::KIND_MINUS) begin
               num_np = NP_SIGN;
               num_neg = 1'b1;
            end else if (tok.kind == cfpw_pkg::KIND_DIGIT) begin
               num_np = NP_DIGITS;
               num_upd = 1'b1;
            end else begin
               num_np = NP_DONE;
            end
         end
         NP_SIGN, NP_DIGITS: begin
            if (tok.kind == cfpw_pkg::KIND_DIGIT) begin
               num_np = NP_DIGITS;
               num_upd = 1'b1;
            end else begin
               num_np = NP_DONE;
            end
         end
         default: begin
            num_np = np_ff;
         end
      endcase
   end

   always_comb begin
      lp_in = lp_ff;
      np_in = np_ff;
      neg_in = neg_ff;
      sacc_in = sacc_ff;
      pacc_in = pacc_ff;
      steer_in = steer_ff;
      speed_in = speed_ff;
      ticks_in = ticks_ff;
      ack = 1'b0;
      if (tok.kind == cfpw_pkg::KIND_TICK) begin
         if (ticks_ff < cfpw_pkg::TICK_CAP) begin
            ticks_in = ticks_ff + 1'b1;
         end
      end else if (tok.kind == cfpw_pkg::KIND_NEWLINE) begin
         if (lp_ff == LP_SPEED) begin
            steer_in = sacc_ff;
            speed_in = pacc_ff;
            ticks_in = '0;
            ack = 1'b1;
         end
         lp_in = LP_START;
         np_in = NP_SPACE;
         neg_in = 1'b0;
      end else begin
         case (lp_ff)
            LP_START: begin
               if (tok.kind == cfpw_pkg::KIND_DOLLAR) begin
                  lp_in = LP_STEER;
                  sacc_in = '0;
                  np_in = NP_SPACE;
                  neg_in = 1'b0;
               end else begin
                  lp_in = LP_SKIP;
               end
            end
            LP_STEER: begin
               if (tok.kind == cfpw_pkg::KIND_COMMA) begin
                  lp_in = LP_SPEED;
                  pacc_in = '0;
                  np_in = NP_SPACE;
                  neg_in = 1'b0;
               end else begin
                  np_in = num_np;
                  neg_in = num_neg;
                  if (num_upd) sacc_in = acc_next;
               end
            end
            LP_SPEED: begin
               np_in = num_np;
               neg_in = num_neg;
               if (num_upd) pacc_in = acc_next;
            end
            default: begin
               lp_in = lp_ff;
            end
         endcase
      end
      // cut the drive whenever the watchdog has run out
      fs = ticks_in > {1'b0, timeout_ff};
      if (fs) speed_in = '0;

      rsp_in.steering_angle = to_out(steer_in);
      rsp_in.drive_speed = to_out(speed_in);
      rsp_in.frame_ack = ack;
      rsp_in.failsafe = fs;
      rsp_valid_in = tok_pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cfpw_pkg::TIMEOUT_RESET;
         lp_ff <= LP_START;
         np_ff <= NP_SPACE;
         neg_ff <= 1'b0;
         sacc_ff <= '0;
         pacc_ff <= '0;
         steer_ff <= cfpw_pkg::STEER_RESET;
         speed_ff <= '0;
         ticks_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (timeout_wr) timeout_ff <= timeout_data;
         rsp_valid_ff <= rsp_valid_in;
         if (tok_pop) begin
            lp_ff <= lp_in;
            np_ff <= np_in;
            neg_ff <= neg_in;
            sacc_ff <= sacc_in;
            pacc_ff <= pacc_in;
            steer_ff <= steer_in;
            speed_ff <= speed_in;
            ticks_ff <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop) rsp_ff <= rsp_in;
   end

endmodule

// ===== hw/rtl/command_frame_parser_watchdog_unit.sv =====
// Command frame parser with drive watchdog: top level.
// Depends on cfpw_pkg, cfpw_front, cfpw_queue and cfpw_back.
//
// Usage:
//   req channel (req_valid / req_stall / req_payload): one item per serial
//   byte (opcode 0, rx_byte) or per millisecond tick (opcode 1).
//   rsp channel (rsp_valid / rsp_stall / rsp_payload): exactly one item per
//   request, carrying steering_angle, drive_speed, frame_ack and failsafe.
//   csr channel (csr_valid / csr_ready / csr_data): writes the watchdog_limit
//   tick count; csr_ready is always high.
// Lines "$steer,speed\n" load steering and speed, pulse frame_ack and clear
// the tick count; once ticks exceed watchdog_limit, speed is forced to zero.
// A result passes through the queue and then the result register before it
// turns valid; a stalled result ahead of it keeps the token in the queue.
// Throughput: one item per cycle while the result is not stalled, since the
// back end parses and accumulates (multiply by ten) each token as it pops.
// Reset (synchronous, active high) empties the queue, drops any pending
// result and restores steering 90, speed 0, watchdog_limit 200.
// While rsp_stall is high the result holds; the two-entry queue keeps taking
// requests until it fills, then req_stall rises.
module command_frame_parser_watchdog_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfpw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfpw_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   cfpw_pkg::token_type front_token;
   cfpw_pkg::token_type queue_token;
   logic                queue_full;
   logic                queue_not_empty;
   logic                queue_pop;
   logic                req_push;

   assign req_stall = queue_full;
   assign req_push = req_valid && !queue_full;
   assign csr_ready = 1'b1;

   cfpw_front u_front (
      .req   (req_payload),
      .token (front_token)
   );

   cfpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_token (front_token),
      .full       (queue_full),
      .pop        (queue_pop),
      .not_empty  (queue_not_empty),
      .pop_token  (queue_token)
   );

   cfpw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tok_valid    (queue_not_empty),
      .tok          (queue_token),
      .tok_pop      (queue_pop),
      .timeout_wr   (csr_valid && csr_ready),
      .timeout_data (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   a_failsafe_cuts_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.failsafe |-> rsp_payload.drive_speed == 16'sd0)
      else $error("failsafe result with nonzero drive speed");

   a_ack_clears_failsafe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_ack |-> !rsp_payload.failsafe)
      else $error("acknowledged frame reported failsafe");

   a_reset_drops_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> queue_pop || rsp_valid)
      else $error("request stalled with nothing pending downstream");

endmodule

// ===== dv/command_frame_parser_watchdog_unit_tb.sv =====
// Testbench for command_frame_parser_watchdog_unit: frame parsing, watchdog and flow control.
// Holds its own predictor of the parser and watchdog; depends on cfpw_pkg and the unit only.
`timescale 1ns / 100ps

module command_frame_parser_watchdog_unit_tb;

   typedef enum logic [1:0] {LINE_START, LINE_STEER, LINE_SPEED, LINE_SKIP} line_state_type;
   typedef enum logic [1:0] {NUM_BLANK, NUM_SIGN, NUM_DIGITS, NUM_DONE} num_state_type;

   localparam logic [7:0] CHAR_VT = 8'h0b;
   localparam logic [7:0] CHAR_FF = 8'h0c;
   localparam int VALUE_MAX = (1 << (cfpw_pkg::VALUE_BITS - 1)) - 1;
   localparam int VALUE_MIN = -VALUE_MAX - 1;
   localparam int RANDOM_ITEMS = 900;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   cfpw_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   cfpw_pkg::rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic [15:0] csr_data;

   command_frame_parser_watchdog_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // predictor state
   line_state_type     line_state;
   num_state_type      num_state;
   logic               num_neg;
   logic signed [15:0] steer_acc;
   logic signed [15:0] speed_acc;
   logic signed [15:0] steer_now;
   logic signed [15:0] speed_now;
   logic [cfpw_pkg::TICK_BITS-1:0]    tick_count;
   logic [cfpw_pkg::TIMEOUT_BITS-1:0] timeout_now;

   cfpw_pkg::rsp_type expected_q[$];
   int      error_count = 0;
   int      items_sent = 0;
   bit      quiet = 1'b0;
   int      hold_request = 0;
   int      stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == cfpw_pkg::CHAR_SPACE ||
             (c >= cfpw_pkg::CHAR_TAB && c <= cfpw_pkg::CHAR_CR);
   endfunction

   function automatic logic signed [15:0] add_digit(logic signed [15:0] acc, logic [3:0] d,
                                                   logic neg);
      int v;
      v = int'(acc) * 10;
      v = neg ? v - int'(d) : v + int'(d);
      if (v > VALUE_MAX) v = VALUE_MAX;
      if (v < VALUE_MIN) v = VALUE_MIN;
      return v[15:0];
   endfunction

   function automatic void feed_number(inout logic signed [15:0] acc, input logic [7:0] c);
      logic is_digit;
      is_digit = c >= cfpw_pkg::CHAR_ZERO && c <= cfpw_pkg::CHAR_NINE;
      case (num_state)
         NUM_BLANK: begin
            if (c == cfpw_pkg::CHAR_PLUS) begin
               num_state = NUM_SIGN;
            end else if (c == cfpw_pkg::CHAR_MINUS) begin
               num_neg = 1'b1;
               num_state = NUM_SIGN;
            end else if (is_digit) begin
               num_state = NUM_DIGITS;
               acc = add_digit(acc, 4'(c - cfpw_pkg::CHAR_ZERO), num_neg);
            end else if (!is_blank(c)) begin
               num_state = NUM_DONE;
            end
         end
         NUM_SIGN, NUM_DIGITS: begin
            if (is_digit) begin
               num_state = NUM_DIGITS;
               acc = add_digit(acc, 4'(c - cfpw_pkg::CHAR_ZERO), num_neg);
            end else begin
               num_state = NUM_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void reset_frame_model();
      line_state = LINE_START;
      num_state = NUM_BLANK;
      num_neg = 1'b0;
      steer_acc = '0;
      speed_acc = '0;
      steer_now = cfpw_pkg::STEER_RESET;
      speed_now = '0;
      tick_count = '0;
      timeout_now = cfpw_pkg::TIMEOUT_RESET;
   endfunction

   function automatic cfpw_pkg::rsp_type predict_frame_result(cfpw_pkg::req_type item);
      cfpw_pkg::rsp_type r;
      logic    ack;
      logic    fail;
      logic [7:0] c;
      ack = 1'b0;
      c = item.rx_byte;
      if (item.opcode == cfpw_pkg::OP_TICK) begin
         if (tick_count < cfpw_pkg::TICK_CAP) tick_count = tick_count + 1'b1;
      end else if (c == cfpw_pkg::CHAR_NEWLINE) begin
         if (line_state == LINE_SPEED) begin
            steer_now = steer_acc;
            speed_now = speed_acc;
            tick_count = '0;
            ack = 1'b1;
         end
         line_state = LINE_START;
         num_state = NUM_BLANK;
         num_neg = 1'b0;
      end else begin
         case (line_state)
            LINE_START: begin
               if (c == cfpw_pkg::CHAR_DOLLAR) begin
                  line_state = LINE_STEER;
                  steer_acc = '0;
                  num_state = NUM_BLANK;
                  num_neg = 1'b0;
               end else begin
                  line_state = LINE_SKIP;
               end
            end
            LINE_STEER: begin
               if (c == cfpw_pkg::CHAR_COMMA) begin
                  line_state = LINE_SPEED;
                  speed_acc = '0;
                  num_state = NUM_BLANK;
                  num_neg = 1'b0;
               end else begin
                  feed_number(steer_acc, c);
               end
            end
            LINE_SPEED: feed_number(speed_acc, c);
            default: ;
         endcase
      end
      fail = tick_count > {1'b0, timeout_now};
      if (fail) speed_now = '0;
      r.steering_angle = steer_now;
      r.drive_speed = speed_now;
      r.frame_ack = ack;
      r.failsafe = fail;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("mismatch %s: got %0d, want %0d", what, got, want);
   endtask

   // predict on accept, compare on result, both sampled at the rising edge
   always @(posedge clock) begin
      cfpw_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) timeout_now = csr_data;
         if (req_valid && !req_stall) expected_q.push_back(predict_frame_result(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with none pending", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.steering_angle !== want.steering_angle)
                  report_mismatch("steering_angle", int'(rsp_payload.steering_angle),
                                  int'(want.steering_angle));
               if (rsp_payload.drive_speed !== want.drive_speed)
                  report_mismatch("drive_speed", int'(rsp_payload.drive_speed),
                                  int'(want.drive_speed));
               if (rsp_payload.frame_ack !== want.frame_ack)
                  report_mismatch("frame_ack", int'(rsp_payload.frame_ack), int'(want.frame_ack));
               if (rsp_payload.failsafe !== want.failsafe)
                  report_mismatch("failsafe", int'(rsp_payload.failsafe), int'(want.failsafe));
            end
         end
      end
   end

   // receiver: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = reset ? 0 : pick_gap();
      end
   end

   // every task that drives starts at a falling edge; valid stays up between items unless a random gap drops it
   task automatic send_item(cfpw_pkg::req_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      items_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic put_char(logic [7:0] c);
      cfpw_pkg::req_type item;
      item.opcode = cfpw_pkg::OP_BYTE;
      item.rx_byte = c;
      send_item(item);
   endtask

   task automatic put_tick();
      cfpw_pkg::req_type item;
      item.opcode = cfpw_pkg::OP_TICK;
      item.rx_byte = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0: return cfpw_pkg::CHAR_SPACE;
         1: return cfpw_pkg::CHAR_TAB;
         2: return CHAR_VT;
         3: return CHAR_FF;
         default: return cfpw_pkg::CHAR_CR;
      endcase
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == cfpw_pkg::CHAR_NEWLINE) c = cfpw_pkg::CHAR_COMMA;
      return c;
   endfunction

   // given byte, sometimes preceded by a tick
   task automatic put_char_ticked(logic [7:0] c);
      if ($urandom_range(0, 5) == 0) put_tick();
      put_char(c);
   endtask

   task automatic put_random_field();
      int r;
      int digits;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_char_ticked(blank_char());
      r = $urandom_range(0, 5);
      if (r < 2) put_char_ticked(cfpw_pkg::CHAR_MINUS);
      else if (r == 2) put_char_ticked(cfpw_pkg::CHAR_PLUS);
      if ($urandom_range(0, 19) == 0) put_char_ticked(blank_char());
      r = $urandom_range(0, 19);
      digits = (r < 2) ? 0 : (r < 17) ? $urandom_range(1, 3) : $urandom_range(4, 6);
      repeat (digits) put_char_ticked(cfpw_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) put_char_ticked(junk_char());
   endtask

   task automatic put_random_line();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         put_char_ticked(cfpw_pkg::CHAR_DOLLAR);
         put_random_field();
         put_char_ticked(cfpw_pkg::CHAR_COMMA);
         put_random_field();
         put_char_ticked(cfpw_pkg::CHAR_NEWLINE);
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 6)) put_char_ticked(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0) put_char_ticked(cfpw_pkg::CHAR_NEWLINE);
      end else if (kind == 8) begin
         // header but no comma
         put_char_ticked(cfpw_pkg::CHAR_DOLLAR);
         put_random_field();
         put_char_ticked(cfpw_pkg::CHAR_NEWLINE);
      end else begin
         repeat ($urandom_range(1, 25)) put_tick();
      end
   endtask

   task automatic reset_state_test();
      put_tick();
      put_text("\n");
   endtask

   task automatic parse_edge_test();
      put_char(8'h00);
      put_text("\n$5\n");
      // overflow both ways, leading blanks, trailing text, a second comma
      put_text("$ -99999,\t+70000z,\n");
      // blank after a sign reads zero
      put_text("$- 4,");
      put_char(8'hff);
      put_text("\n");
   endtask

   task automatic watchdog_test();
      write_timeout(16'd0);
      put_tick();
      put_text("$1,2\n");
      write_timeout(16'd3);
      put_text("$7,9\n");
      repeat (5) put_tick();
      // raise the timeout: failsafe clears, speed stays cut
      write_timeout(16'd100);
      put_tick();
      put_text("$8,-6\n");
   endtask

   task automatic watchdog_limit_test();
      write_timeout(16'd60);
      quiet = 1'b1;
      put_text("$0,1\n");
      repeat (62) put_tick();
      put_text("\n$3,4\n");
      quiet = 1'b0;
   endtask

   task automatic backpressure_test();
      drain_results();
      hold_request = 80;
      quiet = 1'b1;
      repeat (4) begin
         put_text("$12,-34\n");
         put_tick();
      end
      quiet = 1'b0;
      drain_results();
   endtask

   task automatic random_test();
      int start;
      int phase;
      logic [15:0] t;
      start = items_sent;
      phase = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         case (phase % 6)
            0: t = 16'($urandom_range(1, 8));
            1: t = 16'hffff;
            2: t = 16'($urandom_range(9, 40));
            3: t = 16'd0;
            4: t = 16'($urandom_range(0, 65535));
            default: t = cfpw_pkg::TIMEOUT_RESET;
         endcase
         write_timeout(t);
         quiet = (phase % 4 == 3);
         repeat (12) put_random_line();
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      reset_frame_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      reset_state_test();
      parse_edge_test();
      watchdog_test();
      watchdog_limit_test();
      backpressure_test();
      random_test();

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0) report_mismatch("results missing", 0, expected_q.size());
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== command_frame_parser_watchdog_unit.f =====
hw/rtl/cfpw_pkg.sv
hw/rtl/cfpw_front.sv
hw/rtl/cfpw_queue.sv
hw/rtl/cfpw_back.sv
hw/rtl/command_frame_parser_watchdog_unit.sv
dv/command_frame_parser_watchdog_unit_tb.sv
